// File: hdl/spu_pkg.sv
// spray particle update: shared types, constants and fixed-point helpers
`timescale 1ns / 1ps

package spu_pkg;

  // fractional bits of every fixed-point quantity (8 to 24)
  localparam int FRAC_BITS = 16;

  localparam int DT_W  = FRAC_BITS;      // dt, unsigned, always below 1.0
  localparam int F_W   = FRAC_BITS + 1;  // drag factor, unsigned, 0 to 1.0
  localparam int CW    = FRAC_BITS + 4;  // coefficient products, below 16.0
  localparam int SAT_W = 34;             // headroom before saturation
  localparam int MW    = SAT_W + FRAC_BITS;  // raw product width

  localparam int CFG_AW = 3;
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_TIME_STEP   = 1'b0;
  localparam logic [CFG_IW-1:0] REG_WATER_LEVEL = 1'b1;
  localparam logic [15:0]        TIME_STEP_RST   = 16'd1092;

  // physical constants rounded to nearest at FRAC_BITS
  localparam logic [CW-1:0] K_FOAM_DRAG = CW'(((64'd16 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [CW-1:0] K_AIR_DRAG  = CW'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [CW-1:0] K_GRAVITY   = CW'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [CW-1:0] K_GROWTH    = CW'(((64'd25 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [32:0] K_PIN  = 33'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [32:0] K_SINK = 33'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [CW-1:0] ONE_Q = CW'(64'd1 << FRAC_BITS);

  localparam logic signed [MW-1:0] HALF_MW = MW'(64'd1 << (FRAC_BITS - 1));

  typedef logic signed [31:0] q_t;
  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  typedef struct packed {
    q_t          pos_x;
    q_t          pos_y;
    q_t          pos_z;
    q_t          vel_x;
    q_t          vel_y;
    q_t          vel_z;
    q_t          life_left;
    logic [30:0] radius;
    logic        foam;
  } in_word_t;

  typedef struct packed {
    q_t          new_pos_x;
    q_t          new_pos_y;
    q_t          new_pos_z;
    q_t          new_vel_x;
    q_t          new_vel_y;
    q_t          new_vel_z;
    q_t          new_life;
    logic [30:0] new_radius;
    logic        out_foam;
  } out_word_t;

  // coefficients derived from the two config registers
  typedef struct packed {
    logic [DT_W-1:0]  dt;
    logic [F_W-1:0]   drag_foam;
    logic [F_W-1:0]   drag_air;
    logic [CW-1:0]    gdt;
    logic [CW-1:0]    rad_inc;
    q_t               pin_y;
    logic signed [32:0] sink;
  } coef_t;

  // per-stage load strobes
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
    logic ld_e;
  } ctl_t;

  // word handed from the velocity half to the position half
  typedef struct packed {
    q_t          pos_x;
    q_t          pos_y;
    q_t          pos_z;
    q_t          vel_x;
    q_t          vel_y;
    q_t          vel_z;
    q_t          life;
    logic [30:0] radius;
    logic        foam;
  } stage_c_t;

  function automatic q_t sat32(input logic signed [SAT_W-1:0] v);
    q_t r;
    if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31])) begin
      r = v[31:0];
    end else if (v[SAT_W-1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  // signed value times unsigned factor, full width
  function automatic logic signed [MW-1:0] mulq(input q_t a, input logic [F_W-1:0] b);
    logic signed [MW-1:0] ae;
    logic signed [MW-1:0] be;
    ae = MW'(a);
    be = $signed(MW'(b));
    return ae * be;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic logic signed [SAT_W-1:0] rnd(input logic signed [MW-1:0] p);
    logic signed [MW-1:0] t;
    t = p + HALF_MW;
    return t[MW-1:FRAC_BITS];
  endfunction

endpackage

// File: hdl/spu_cfg.sv
// spray particle update: register port and derived coefficients
`timescale 1ns / 1ps

module spu_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spu_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output spu_pkg::coef_t               coef,
  output logic                         busy
);

  localparam int PW = spu_pkg::DT_W + spu_pkg::CW;
  localparam logic [1:0] SETTLE = 2'd3;

  logic [15:0]   time_step_r;
  spu_pkg::q_t   water_level_r;
  logic [1:0]    settle_r, settle_nxt;
  logic          wr;
  logic [spu_pkg::CFG_IW-1:0] idx;

  logic [15+spu_pkg::FRAC_BITS:0] ts_ext;
  logic [spu_pkg::DT_W-1:0]       dt;

  logic [PW-1:0] p_fd_r, p_air_r, p_g_r, p_rad_r;
  logic [spu_pkg::DT_W-1:0] dt1_r;
  spu_pkg::coef_t coef_r, coef_nxt;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[spu_pkg::CFG_AW-1:2];

  always_comb begin
    case (idx)
      spu_pkg::REG_TIME_STEP:   prdata = {16'b0, time_step_r};
      spu_pkg::REG_WATER_LEVEL: prdata = water_level_r;
      default:                  prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= spu_pkg::TIME_STEP_RST;
      water_level_r <= '0;
    end else if (wr) begin
      case (idx)
        spu_pkg::REG_TIME_STEP:   time_step_r   <= pwdata[15:0];
        spu_pkg::REG_WATER_LEVEL: water_level_r <= pwdata;
        default: ;
      endcase
    end
  end

  // hold off items until the coefficient pipe has caught up
  always_comb begin
    if (wr) begin
      settle_nxt = SETTLE;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign busy = (settle_r != 2'd0);

  // Q0.16 time step brought to FRAC_BITS
  assign ts_ext = {time_step_r, spu_pkg::FRAC_BITS'(0)};
  assign dt     = ts_ext[15+spu_pkg::FRAC_BITS:16];

  always_ff @(posedge clk) begin
    dt1_r   <= dt;
    p_fd_r  <= PW'(dt) * PW'(spu_pkg::K_FOAM_DRAG);
    p_air_r <= PW'(dt) * PW'(spu_pkg::K_AIR_DRAG);
    p_g_r   <= PW'(dt) * PW'(spu_pkg::K_GRAVITY);
    p_rad_r <= PW'(dt) * PW'(spu_pkg::K_GROWTH);
  end

  function automatic logic [spu_pkg::CW-1:0] rnd_c(input logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = p + PW'(spu_pkg::HALF_MW);
    return t[PW-1:spu_pkg::FRAC_BITS];
  endfunction

  // 1 - k*dt, clamped at zero
  function automatic logic [spu_pkg::F_W-1:0] drag(input logic [spu_pkg::CW-1:0] m);
    logic signed [spu_pkg::CW:0] d;
    d = $signed({1'b0, spu_pkg::ONE_Q}) - $signed({1'b0, m});
    return d[spu_pkg::CW] ? '0 : d[spu_pkg::F_W-1:0];
  endfunction

  always_comb begin
    coef_nxt.dt        = dt1_r;
    coef_nxt.drag_foam = drag(rnd_c(p_fd_r));
    coef_nxt.drag_air  = drag(rnd_c(p_air_r));
    coef_nxt.gdt       = rnd_c(p_g_r);
    coef_nxt.rad_inc   = rnd_c(p_rad_r);
    coef_nxt.pin_y     = spu_pkg::sat32(spu_pkg::SAT_W'(water_level_r)
                                        + spu_pkg::SAT_W'(spu_pkg::K_PIN));
    coef_nxt.sink      = 33'(water_level_r) - spu_pkg::K_SINK;
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  assign coef = coef_r;

endmodule

// File: hdl/spu_ctl.sv
// spray particle update: stage valid bits and load strobes
`timescale 1ns / 1ps

module spu_ctl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          busy,
  input  logic          alive,
  output spu_pkg::ctl_t ctl
);

  logic va_r, vb_r, vc_r, vd_r, ve_r;
  logic va_nxt, vb_nxt, vc_nxt, vd_nxt, ve_nxt;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic take;

  // a stage takes a word when empty or when it moves on itself
  assign rdy_e = !ve_r || !out_stall;
  assign rdy_d = !vd_r || rdy_e;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;

  assign take     = in_valid && !busy;
  assign in_stall = busy || !rdy_a;

  always_comb begin
    va_nxt = rdy_a ? take : va_r;
    vb_nxt = rdy_b ? va_r : vb_r;
    vc_nxt = rdy_c ? vb_r : vc_r;
    vd_nxt = rdy_d ? vc_r : vd_r;
    ve_nxt = rdy_e ? (vd_r && alive) : ve_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
      vd_r <= vd_nxt;
      ve_r <= ve_nxt;
    end
  end

  assign ctl.ld_a = rdy_a && take;
  assign ctl.ld_b = rdy_b && va_r;
  assign ctl.ld_c = rdy_c && vb_r;
  assign ctl.ld_d = rdy_d && vc_r;
  assign ctl.ld_e = rdy_e && vd_r;

  assign out_valid = ve_r;

endmodule

// File: hdl/spu_vel.sv
// spray particle update: gravity, drag and life/size stages
`timescale 1ns / 1ps

module spu_vel (
  input  logic              clk,
  input  spu_pkg::ctl_t     ctl,
  input  spu_pkg::coef_t    coef,
  input  spu_pkg::in_word_t in_data,
  output spu_pkg::stage_c_t c_data
);

  localparam int SW = spu_pkg::SAT_W;
  localparam int MW = spu_pkg::MW;

  spu_pkg::in_word_t a_r;
  spu_pkg::q_t       a_vyd_r, a_vyd_nxt;

  logic signed [MW-1:0] b_mvf_r [3];
  logic signed [MW-1:0] b_mvf_nxt [3];
  logic signed [MW-1:0] b_mvx_r, b_mvz_r, b_mvx_nxt, b_mvz_nxt;
  spu_pkg::q_t          b_pos_r [3];
  spu_pkg::q_t          b_life_r, b_life_nxt;
  logic [30:0]          b_rad_r, b_rad_nxt;
  logic                 b_foam_r;

  spu_pkg::stage_c_t c_r, c_nxt;

  spu_pkg::q_t          a_vel [3];
  logic [spu_pkg::F_W-1:0] f_sel;
  logic [31:0]          rad_sum;
  spu_pkg::q_t          vnew [3];

  // droplet gravity on the way in
  assign a_vyd_nxt = spu_pkg::sat32(SW'(in_data.vel_y) - $signed(SW'(coef.gdt)));

  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      a_r     <= in_data;
      a_vyd_r <= a_vyd_nxt;
    end
  end

  // multiplier stage: velocity times drag, old velocity times dt, life and radius steps
  always_comb begin
    a_vel[0] = a_r.vel_x;
    a_vel[1] = a_r.foam ? a_r.vel_y : a_vyd_r;
    a_vel[2] = a_r.vel_z;
    f_sel    = a_r.foam ? coef.drag_foam : coef.drag_air;
    for (int i = 0; i < 3; i++) begin
      b_mvf_nxt[i] = spu_pkg::mulq(a_vel[i], f_sel);
    end
    b_mvx_nxt  = spu_pkg::mulq(a_r.vel_x, spu_pkg::F_W'(coef.dt));
    b_mvz_nxt  = spu_pkg::mulq(a_r.vel_z, spu_pkg::F_W'(coef.dt));
    b_life_nxt = spu_pkg::sat32(SW'(a_r.life_left) - $signed(SW'(coef.dt)));
    rad_sum    = 32'(a_r.radius) + 32'(coef.rad_inc);
    if (!a_r.foam) begin
      b_rad_nxt = a_r.radius;
    end else if (rad_sum[31]) begin
      b_rad_nxt = '1;
    end else begin
      b_rad_nxt = rad_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_b) begin
      for (int i = 0; i < 3; i++) begin
        b_mvf_r[i] <= b_mvf_nxt[i];
      end
      b_mvx_r    <= b_mvx_nxt;
      b_mvz_r    <= b_mvz_nxt;
      b_pos_r[0] <= a_r.pos_x;
      b_pos_r[1] <= a_r.pos_y;
      b_pos_r[2] <= a_r.pos_z;
      b_life_r   <= b_life_nxt;
      b_rad_r    <= b_rad_nxt;
      b_foam_r   <= a_r.foam;
    end
  end

  // rounding stage; foam moves on its old velocity and is pinned to the surface
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vnew[i] = spu_pkg::sat32(spu_pkg::rnd(b_mvf_r[i]));
    end
    c_nxt.vel_x  = vnew[0];
    c_nxt.vel_y  = vnew[1];
    c_nxt.vel_z  = vnew[2];
    c_nxt.life   = b_life_r;
    c_nxt.radius = b_rad_r;
    c_nxt.foam   = b_foam_r;
    if (b_foam_r) begin
      c_nxt.pos_x = spu_pkg::sat32(SW'(b_pos_r[0]) + spu_pkg::rnd(b_mvx_r));
      c_nxt.pos_y = coef.pin_y;
      c_nxt.pos_z = spu_pkg::sat32(SW'(b_pos_r[2]) + spu_pkg::rnd(b_mvz_r));
    end else begin
      c_nxt.pos_x = b_pos_r[0];
      c_nxt.pos_y = b_pos_r[1];
      c_nxt.pos_z = b_pos_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_c) begin
      c_r <= c_nxt;
    end
  end

  assign c_data = c_r;

endmodule

// File: hdl/spu_pos.sv
// spray particle update: droplet motion, survival test and output register
`timescale 1ns / 1ps

module spu_pos (
  input  logic               clk,
  input  spu_pkg::ctl_t      ctl,
  input  spu_pkg::coef_t     coef,
  input  spu_pkg::stage_c_t  c_data,
  output logic               alive,
  output spu_pkg::out_word_t out_data
);

  localparam int SW = spu_pkg::SAT_W;
  localparam int MW = spu_pkg::MW;

  logic signed [MW-1:0] d_mvp_r [3];
  logic signed [MW-1:0] d_mvp_nxt [3];
  spu_pkg::stage_c_t    d_r;

  spu_pkg::q_t        c_vel [3];
  spu_pkg::q_t        d_pos [3];
  spu_pkg::q_t        p_new [3];
  spu_pkg::out_word_t e_r, e_nxt;

  // multiplier stage: new velocity times dt
  always_comb begin
    c_vel[0] = c_data.vel_x;
    c_vel[1] = c_data.vel_y;
    c_vel[2] = c_data.vel_z;
    for (int i = 0; i < 3; i++) begin
      d_mvp_nxt[i] = spu_pkg::mulq(c_vel[i], spu_pkg::F_W'(coef.dt));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_d) begin
      for (int i = 0; i < 3; i++) begin
        d_mvp_r[i] <= d_mvp_nxt[i];
      end
      d_r <= c_data;
    end
  end

  always_comb begin
    d_pos[0] = d_r.pos_x;
    d_pos[1] = d_r.pos_y;
    d_pos[2] = d_r.pos_z;
    for (int i = 0; i < 3; i++) begin
      p_new[i] = d_r.foam ? d_pos[i]
                          : spu_pkg::sat32(SW'(d_pos[i]) + spu_pkg::rnd(d_mvp_r[i]));
    end
    // droplets also die once sunk below the water band
    alive = (d_r.life > 32'sd0) &&
            (d_r.foam || !($signed(33'(p_new[1])) < coef.sink));
    e_nxt.new_pos_x  = p_new[0];
    e_nxt.new_pos_y  = p_new[1];
    e_nxt.new_pos_z  = p_new[2];
    e_nxt.new_vel_x  = d_r.vel_x;
    e_nxt.new_vel_y  = d_r.vel_y;
    e_nxt.new_vel_z  = d_r.vel_z;
    e_nxt.new_life   = d_r.life;
    e_nxt.new_radius = d_r.radius;
    e_nxt.out_foam   = d_r.foam;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_e) begin
      e_r <= e_nxt;
    end
  end

  assign out_data = e_r;

endmodule

// File: hdl/spray_particle_update.sv
// spray particle update: top level
`timescale 1ns / 1ps
// stages: input register, drag multiply, rounding, dt multiply, output register
//   (the output register drives out_valid)
// throughput: one particle per cycle when not stalled; dead ones leave a bubble
// a config write holds in_stall high while the coefficients settle
// reset: synchronous, active low; clears every stage valid, time_step to 1092,
//   water_level to 0, and starts the coefficient settle count

module spray_particle_update (
  input  logic                       clk,
  input  logic                       rst_n,
  // particle input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  spu_pkg::in_word_t          in_data,
  // surviving particle output
  output logic                       out_valid,
  input  logic                       out_stall,
  output spu_pkg::out_word_t         out_data,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spu_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  spu_pkg::coef_t    coef;
  spu_pkg::ctl_t     ctl;
  spu_pkg::stage_c_t c_data;
  logic              busy;
  logic              alive;

  // time_step / water_level registers and the derived coefficients
  // (drag factors, gravity step, growth step, pinned height, sink line)
  spu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef),
    .busy    (busy)
  );

  // valid bits per stage; a stage loads when empty or draining, so bubbles
  // from dead particles get squeezed out under output stall
  spu_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .busy      (busy),
    .alive     (alive),
    .ctl       (ctl)
  );

  // stages a to c: gravity, drag, life and size, foam position and pinning
  spu_vel u_vel (
    .clk     (clk),
    .ctl     (ctl),
    .coef    (coef),
    .in_data (in_data),
    .c_data  (c_data)
  );

  // stages d and e: droplet motion, survival test, output word
  spu_pos u_pos (
    .clk      (clk),
    .ctl      (ctl),
    .coef     (coef),
    .c_data   (c_data),
    .alive    (alive),
    .out_data (out_data)
  );

endmodule

// File: hdl/spu_checker.sv
// spray particle update: port-level checks and their bind
`timescale 1ns / 1ps

module spu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spu_pkg::out_word_t out_data,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic               pready
);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;

  // a held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  // only live particles come out
  a_life_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.new_life > 32'sd0))
    else $error("word with non-positive life delivered");

  // no item may enter on stale coefficients
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> in_stall ##1 in_stall)
    else $error("input taken right after a register write");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind spray_particle_update spu_checker u_spu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready)
);

// File: tb/sv/testbench.sv
// testbench for spray_particle_update: bit-exact particle step prediction and word checking
`timescale 1ns / 1ps

module testbench;

  // constants of the physics, rounded to nearest at FRAC_BITS
  localparam longint ONE_FX     = longint'(1) << spu_pkg::FRAC_BITS;
  localparam longint FOAM_DRAG  = ((longint'(16) << spu_pkg::FRAC_BITS) + 5) / 10;
  localparam longint AIR_DRAG   = ((longint'(6) << spu_pkg::FRAC_BITS) + 5) / 10;
  localparam longint GRAVITY    = ((longint'(981) << spu_pkg::FRAC_BITS) + 50) / 100;
  localparam longint GROWTH     = ((longint'(25) << spu_pkg::FRAC_BITS) + 5) / 10;
  localparam longint PIN_HEIGHT = ((longint'(3) << spu_pkg::FRAC_BITS) + 50) / 100;
  localparam longint SINK_DEPTH = ((longint'(3) << spu_pkg::FRAC_BITS) + 5) / 10;
  localparam longint RAD_MAX    = 64'h7fffffff;
  localparam int     ITEMS_PER_PHASE = 75;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  spu_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  spu_pkg::out_word_t out_data;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [spu_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  spray_particle_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // particles waiting to be sent and survivors waiting to come out
  spu_pkg::in_word_t  particle_q[$];
  spu_pkg::out_word_t survivor_q[$];
  int                 mismatch_cnt = 0;

  // our copy of the two registers, reset values
  logic [15:0] step_reg = spu_pkg::TIME_STEP_RST;
  spu_pkg::q_t level_reg = '0;

  // ---------------------------------------------------------------------------
  // fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------

  // product rounded to nearest, ties toward plus infinity (floor after adding half)
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b + (longint'(1) << (spu_pkg::FRAC_BITS - 1))) >>> spu_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp_q(input longint x);
    if (x > longint'(spu_pkg::Q_MAX)) return longint'(spu_pkg::Q_MAX);
    if (x < longint'(spu_pkg::Q_MIN)) return longint'(spu_pkg::Q_MIN);
    return x;
  endfunction

  // one euler step; returns 1 when the particle survives
  function automatic bit advance_particle(input spu_pkg::in_word_t w,
                                          input logic [15:0] ts,
                                          input spu_pkg::q_t level,
                                          output spu_pkg::out_word_t r);
    longint pos[3];
    longint vel[3];
    longint dt;
    longint life;
    longint rad;
    longint drag;
    longint wl;
    bit     dead;
    if (spu_pkg::FRAC_BITS >= 16) dt = longint'(ts) << (spu_pkg::FRAC_BITS - 16);
    else dt = longint'(ts) >> (16 - spu_pkg::FRAC_BITS);
    wl = longint'(level);
    pos[0] = longint'(w.pos_x);
    pos[1] = longint'(w.pos_y);
    pos[2] = longint'(w.pos_z);
    vel[0] = longint'(w.vel_x);
    vel[1] = longint'(w.vel_y);
    vel[2] = longint'(w.vel_z);
    life = longint'(w.life_left);
    rad = longint'(w.radius);
    if (w.foam) begin
      // foam: move on old velocity, pin to the surface, then heavy drag
      drag = ONE_FX - fx_mul(dt, FOAM_DRAG);
      if (drag < 0) drag = 0;
      for (int i = 0; i < 3; i++) pos[i] = clamp_q(pos[i] + fx_mul(vel[i], dt));
      pos[1] = clamp_q(wl + PIN_HEIGHT);
      for (int i = 0; i < 3; i++) vel[i] = clamp_q(fx_mul(vel[i], drag));
      rad = rad + fx_mul(dt, GROWTH);
      if (rad > RAD_MAX) rad = RAD_MAX;
      life = clamp_q(life - dt);
      dead = (life <= 0);
    end else begin
      // droplet: gravity, air drag, then move on the new velocity
      vel[1] = clamp_q(vel[1] - fx_mul(dt, GRAVITY));
      drag = ONE_FX - fx_mul(dt, AIR_DRAG);
      if (drag < 0) drag = 0;
      for (int i = 0; i < 3; i++) vel[i] = clamp_q(fx_mul(vel[i], drag));
      for (int i = 0; i < 3; i++) pos[i] = clamp_q(pos[i] + fx_mul(vel[i], dt));
      life = clamp_q(life - dt);
      // sink threshold is exact, no saturation
      dead = (life <= 0) || (pos[1] < wl - SINK_DEPTH);
    end
    r.new_pos_x  = spu_pkg::q_t'(pos[0]);
    r.new_pos_y  = spu_pkg::q_t'(pos[1]);
    r.new_pos_z  = spu_pkg::q_t'(pos[2]);
    r.new_vel_x  = spu_pkg::q_t'(vel[0]);
    r.new_vel_y  = spu_pkg::q_t'(vel[1]);
    r.new_vel_z  = spu_pkg::q_t'(vel[2]);
    r.new_life   = spu_pkg::q_t'(life);
    r.new_radius = 31'(rad);
    r.out_foam   = w.foam;
    return !dead;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // the slot is free: either nothing was offered or the word was taken
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (particle_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= particle_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // a third of the bursts follow back to back
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern: duty redrawn as stall_age wraps, sometimes no stall
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int stall_age = 0;

  always @(posedge clk) begin
    if (stall_age == 199) begin
      stall_age <= 0;
      case ($urandom_range(0, 3))
        0: begin
          stall_pct <= 0;
        end
        1: begin
          stall_pct <= 30;
        end
        2: begin
          stall_pct <= 60;
        end
        default: begin
          stall_pct <= 90;
        end
      endcase
    end else begin
      stall_age <= stall_age + 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each taken result word, then predicts each taken particle
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    spu_pkg::out_word_t e;
    spu_pkg::out_word_t pred;
    if (rst_n && out_valid && !out_stall) begin
      if (survivor_q.size() == 0) begin
        $error("result word with no particle expected to survive");
        mismatch_cnt++;
      end else begin
        e = survivor_q.pop_front();
        check_field("new_pos_x", e.new_pos_x, out_data.new_pos_x);
        check_field("new_pos_y", e.new_pos_y, out_data.new_pos_y);
        check_field("new_pos_z", e.new_pos_z, out_data.new_pos_z);
        check_field("new_vel_x", e.new_vel_x, out_data.new_vel_x);
        check_field("new_vel_y", e.new_vel_y, out_data.new_vel_y);
        check_field("new_vel_z", e.new_vel_z, out_data.new_vel_z);
        check_field("new_life", e.new_life, out_data.new_life);
        check_field("new_radius", e.new_radius, out_data.new_radius);
        check_field("out_foam", e.out_foam, out_data.out_foam);
      end
    end
    // registers only change while idle, so the copy is current here
    if (rst_n && in_valid && !in_stall) begin
      if (advance_particle(in_data, step_reg, level_reg, pred)) survivor_q.push_back(pred);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic spu_pkg::in_word_t make_particle(
      input spu_pkg::q_t px, input spu_pkg::q_t py, input spu_pkg::q_t pz,
      input spu_pkg::q_t vx, input spu_pkg::q_t vy, input spu_pkg::q_t vz,
      input spu_pkg::q_t life, input logic [30:0] rad, input logic foam);
    spu_pkg::in_word_t w;
    w.pos_x = px;
    w.pos_y = py;
    w.pos_z = pz;
    w.vel_x = vx;
    w.vel_y = vy;
    w.vel_z = vz;
    w.life_left = life;
    w.radius = rad;
    w.foam = foam;
    return w;
  endfunction

  // signed value spread over +-span (whole units)
  function automatic spu_pkg::q_t spread(input int span);
    return spu_pkg::q_t'($urandom_range(0, 2 * span * 65536)) - spu_pkg::q_t'(span * 65536);
  endfunction

  // mostly plausible particles near the water, a quarter raw noise
  function automatic spu_pkg::in_word_t random_particle();
    spu_pkg::in_word_t w;
    if ($urandom_range(0, 3) == 0) begin
      w = make_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, 31'($urandom), 1'($urandom));
    end else begin
      w = make_particle(spread(100),
                        level_reg + spu_pkg::q_t'($urandom_range(0, 5 * 65536))
                        - spu_pkg::q_t'(13107), spread(100), spread(20), spread(20),
                        spread(20), spu_pkg::q_t'($urandom_range(1, 10 * 65536)),
                        31'($urandom_range(0, 65536)), 1'($urandom));
    end
    return w;
  endfunction

  task automatic write_reg(input logic [spu_pkg::CFG_IW-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= spu_pkg::CFG_AW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == spu_pkg::REG_TIME_STEP) step_reg = value[15:0];
    else level_reg = spu_pkg::q_t'(value);
  endtask

  // wait until every particle is out, then let the pipe drain dead words too
  task automatic wait_idle();
    @(negedge clk);
    while (particle_q.size() != 0 || survivor_q.size() != 0 || in_valid) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_phase(input logic [15:0] ts, input logic [31:0] level);
    write_reg(spu_pkg::REG_TIME_STEP, 32'(ts));
    write_reg(spu_pkg::REG_WATER_LEVEL, level);
    @(negedge clk);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) particle_q.push_back(random_particle());
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed set at reset settings (dt about 1/60 s, water at zero)
    @(negedge clk);
    // plain droplet and foam at rest
    particle_q.push_back(make_particle(0, 32'sh10000, 0, 0, 0, 0, 32'sh10000, 31'h1999, 1'b0));
    particle_q.push_back(make_particle(0, 32'sh10000, 0, 0, 0, 0, 32'sh10000, 31'h1999, 1'b1));
    // life already gone, life exactly dt, life one above dt
    particle_q.push_back(make_particle(0, 32'sh10000, 0, 0, 0, 0, 0, 31'h100, 1'b0));
    particle_q.push_back(make_particle(0, 0, 0, 0, 0, 0, 32'sd1092, 31'h100, 1'b1));
    particle_q.push_back(make_particle(0, 0, 0, 0, 0, 0, 32'sd1093, 31'h100, 1'b1));
    // life extremes
    particle_q.push_back(make_particle(0, 32'sh10000, 0, 0, 0, 0, spu_pkg::Q_MIN, 31'h0,
                                       1'b0));
    particle_q.push_back(make_particle(0, 32'sh10000, 0, 0, 0, 0, spu_pkg::Q_MAX, 31'h0,
                                       1'b0));
    // droplet at the sink line, far below it, and just at the surface
    particle_q.push_back(make_particle(0, -32'sd19661, 0, 0, 0, 0, 32'sh10000, 31'h0, 1'b0));
    particle_q.push_back(make_particle(0, -32'sh50000, 0, 0, 0, 0, 32'sh10000, 31'h0, 1'b0));
    particle_q.push_back(make_particle(0, 0, 0, 0, 0, 0, 32'sh10000, 31'h0, 1'b0));
    // position and velocity saturation both ways
    particle_q.push_back(make_particle(spu_pkg::Q_MAX, spu_pkg::Q_MAX, spu_pkg::Q_MAX,
                                       spu_pkg::Q_MAX, spu_pkg::Q_MAX, spu_pkg::Q_MAX,
                                       spu_pkg::Q_MAX, 31'h7fffffff, 1'b0));
    particle_q.push_back(make_particle(spu_pkg::Q_MIN, spu_pkg::Q_MIN, spu_pkg::Q_MIN,
                                       spu_pkg::Q_MIN, spu_pkg::Q_MIN, spu_pkg::Q_MIN,
                                       spu_pkg::Q_MAX, 31'h7fffffff, 1'b1));
    particle_q.push_back(make_particle(spu_pkg::Q_MAX, spu_pkg::Q_MAX, spu_pkg::Q_MAX,
                                       spu_pkg::Q_MAX, spu_pkg::Q_MAX, spu_pkg::Q_MAX,
                                       spu_pkg::Q_MAX, 31'h7fffffff, 1'b1));
    particle_q.push_back(make_particle(spu_pkg::Q_MIN, 32'sh10000, spu_pkg::Q_MIN,
                                       spu_pkg::Q_MIN, spu_pkg::Q_MIN, spu_pkg::Q_MIN,
                                       spu_pkg::Q_MAX, 31'h0, 1'b0));
    // radius growth right below the ceiling
    particle_q.push_back(make_particle(0, 0, 0, 0, 0, 0, 32'sh10000, 31'h7ffffc00, 1'b1));
    // alternating bit patterns
    particle_q.push_back(make_particle(32'sh55555555, 32'sh55555555, 32'sh55555555,
                                       32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
                                       32'sh55555555, 31'h2aaaaaaa, 1'b1));
    particle_q.push_back(make_particle(32'shaaaaaaaa, 32'sh2aaaaaaa, 32'shaaaaaaaa,
                                       32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
                                       32'sh2aaaaaaa, 31'h55555555, 1'b0));
    for (int i = 0; i < ITEMS_PER_PHASE; i++) particle_q.push_back(random_particle());
    wait_idle();

    // register settings, extremes first
    random_phase(16'd0, 32'h7fffffff);
    random_phase(16'hffff, 32'h80000000);
    random_phase(16'd40960, 32'h00010000);
    random_phase(16'($urandom), 32'($urandom_range(0, 20 * 65536)) - 32'(10 * 65536));
    random_phase(16'($urandom), $urandom);
    random_phase(16'($urandom_range(0, 4096)), 32'h0);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
